// ===== hdl/idm_pkg.sv =====
// shared types, constants and helpers of the pixel difference metric
`default_nettype none

package idm_pkg;

	localparam int MAX_DIMENSION_DEF = 4096;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int PIXEL_W   = 32;
	localparam int CHAN_W    = 8;
	localparam int COUNT_W   = 25;
	localparam int CFG_DIM_W = 13;
	localparam int CFG_EN_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam int RED_LSB   = 16;
	localparam int GREEN_LSB = 8;
	localparam int BLUE_LSB  = 0;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CHAN_W-1:0]  CHAN_MAX = '1;
	localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = '1;
	localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 32'hFFFF_FFFF;
	localparam logic [PIXEL_W-1:0] BLACK_PIXEL = 32'hFF00_0000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAPS_ENABLE  = 2'd2;

	// enable bits of the map enable register
	localparam int EN_MASK  = 0;
	localparam int EN_RGB   = 1;
	localparam int EN_WHITE = 2;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic mul;
		logic rem_load;
		logic div_step;
		logic pend_emit;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
	} status_t;

	function automatic logic [CHAN_W-1:0] abs_chan(
		input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b
	);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/idm_if.sv =====
// channel interfaces: pixel pairs in, results out, configuration writes
`default_nettype none

interface idm_pixel_if;
	import idm_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] baseline_pixel;
	logic [PIXEL_W-1:0] test_pixel;
	modport source (output valid, baseline_pixel, test_pixel, input ready);
	modport sink (input valid, baseline_pixel, test_pixel, output ready);
endinterface

interface idm_result_if #(
	parameter int FRACTION_BITS = idm_pkg::FRACTION_BITS_DEF
);
	import idm_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   pixel_differs;
	logic [CHAN_W-1:0]      mask_alpha;
	logic [PIXEL_W-1:0]     rgb_diff_pixel;
	logic [PIXEL_W-1:0]     white_diff_pixel;
	logic                   frame_done;
	logic [COUNT_W-1:0]     differing_count;
	logic [CHAN_W-1:0]      max_red_diff;
	logic [CHAN_W-1:0]      max_green_diff;
	logic [CHAN_W-1:0]      max_blue_diff;
	logic [FRACTION_BITS:0] identical_fraction;
	modport source (
		output valid, pixel_differs, mask_alpha, rgb_diff_pixel, white_diff_pixel,
		frame_done, differing_count, max_red_diff, max_green_diff, max_blue_diff,
		identical_fraction,
		input ready
	);
	modport sink (
		input valid, pixel_differs, mask_alpha, rgb_diff_pixel, white_diff_pixel,
		frame_done, differing_count, max_red_diff, max_green_diff, max_blue_diff,
		identical_fraction,
		output ready
	);
endinterface

interface idm_cfg_if;
	import idm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/image_pixel_difference_metric.sv =====
// an ordinary pixel's result is registered and valid in the cycle after its take
// the last pixel of a frame is held while the multiply, the load, the FRACTION_BITS+1
// steps of the bit-serial divider and the emit run; the emit waits for a free output
// throughput: one pixel a cycle while the output is free, none during that sequence
// reset: width 1, height 1, all maps on, position and totals zero; no clearing pass
`default_nettype none

module image_pixel_difference_metric #(
	parameter int MAX_DIMENSION = idm_pkg::MAX_DIMENSION_DEF,
	parameter int FRACTION_BITS = idm_pkg::FRACTION_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	idm_cfg_if.sink    cfg,
	idm_pixel_if.sink  pixels,
	idm_result_if.source result
);
	import idm_pkg::*;

	// commands from the controller, frame-end status back from the datapath
	cmd_t    cmd;
	status_t status;
	logic    in_ready;
	logic    out_valid;

	// registers take a write in any cycle
	assign cfg.ready = 1'b1;

	assign pixels.ready = in_ready;
	assign result.valid = out_valid;

	// sequencing: streaming, then multiply, load, divide and emit at frame end
	idm_ctrl #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.out_ready(result.ready),
		.status   (status),
		.cmd      (cmd),
		.in_ready (in_ready),
		.out_valid(out_valid)
	);

	// compare, totals, divider and the output register
	idm_datapath #(
		.MAX_DIMENSION(MAX_DIMENSION),
		.FRACTION_BITS(FRACTION_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.baseline_pixel    (pixels.baseline_pixel),
		.test_pixel        (pixels.test_pixel),
		.cmd               (cmd),
		.status            (status),
		.pixel_differs     (result.pixel_differs),
		.mask_alpha        (result.mask_alpha),
		.rgb_diff_pixel    (result.rgb_diff_pixel),
		.white_diff_pixel  (result.white_diff_pixel),
		.frame_done        (result.frame_done),
		.differing_count   (result.differing_count),
		.max_red_diff      (result.max_red_diff),
		.max_green_diff    (result.max_green_diff),
		.max_blue_diff     (result.max_blue_diff),
		.identical_fraction(result.identical_fraction)
	);

endmodule

`default_nettype wire

// ===== hdl/idm_ctrl.sv =====
// controller state machine: pixel streaming, end-of-frame division sequence
`default_nettype none

module idm_ctrl #(
	parameter int FRACTION_BITS = idm_pkg::FRACTION_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             out_ready,
	input  wire idm_pkg::status_t status,
	output idm_pkg::cmd_t         cmd,
	output logic                  in_ready,
	output logic                  out_valid
);
	import idm_pkg::*;

	localparam int CNT_W = $clog2(FRACTION_BITS + 1);

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] step_cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_RUN: begin
				if (in_valid && out_free && status.frame_end)
					state_nxt = ST_MUL;
			end
			ST_MUL:  state_nxt = ST_LOAD;
			ST_LOAD: state_nxt = ST_DIV;
			ST_DIV: begin
				if (step_cnt_q == '0)
					state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free)
					state_nxt = ST_RUN;
			end
			default: state_nxt = ST_RUN;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_RUN: begin
				in_ready = out_free;
				cmd.take = in_valid && out_free;
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_LOAD: cmd.rem_load = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_EMIT: cmd.pend_emit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			step_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.rem_load)
				step_cnt_q <= CNT_W'(FRACTION_BITS);
			else if (cmd.div_step)
				step_cnt_q <= step_cnt_q - CNT_W'(1);
			if ((cmd.take && !status.frame_end) || cmd.pend_emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/idm_datapath.sv =====
// datapath: config registers, pixel compare, frame totals, divider, output register
`default_nettype none

module idm_datapath #(
	parameter int MAX_DIMENSION = idm_pkg::MAX_DIMENSION_DEF,
	parameter int FRACTION_BITS = idm_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [idm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [idm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [idm_pkg::PIXEL_W-1:0]    baseline_pixel,
	input  wire logic [idm_pkg::PIXEL_W-1:0]    test_pixel,
	input  wire idm_pkg::cmd_t                  cmd,
	output idm_pkg::status_t                    status,
	output logic                                pixel_differs,
	output logic [idm_pkg::CHAN_W-1:0]          mask_alpha,
	output logic [idm_pkg::PIXEL_W-1:0]         rgb_diff_pixel,
	output logic [idm_pkg::PIXEL_W-1:0]         white_diff_pixel,
	output logic                                frame_done,
	output logic [idm_pkg::COUNT_W-1:0]         differing_count,
	output logic [idm_pkg::CHAN_W-1:0]          max_red_diff,
	output logic [idm_pkg::CHAN_W-1:0]          max_green_diff,
	output logic [idm_pkg::CHAN_W-1:0]          max_blue_diff,
	output logic [FRACTION_BITS:0]              identical_fraction
);
	import idm_pkg::*;

	localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
	localparam int POS_W   = $clog2(MAX_DIMENSION);
	localparam int CLAMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
	localparam int TOT_W   = 2 * DIM_W;
	localparam int REM_W   = TOT_W + 1;
	localparam int SUB_W   = (TOT_W > COUNT_W) ? TOT_W : COUNT_W;
	localparam int FRAC_W  = FRACTION_BITS + 1;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
		logic [CLAMP_W-1:0] ext;
		ext = CLAMP_W'(v);
		if (ext == '0)
			return DIM_W'(1);
		else if (ext > CLAMP_W'(MAX_DIMENSION))
			return DIM_W'(MAX_DIMENSION);
		else
			return DIM_W'(ext);
	endfunction

	// configuration
	logic [CFG_DIM_W-1:0] width_q;
	logic [CFG_DIM_W-1:0] height_q;
	logic [CFG_EN_W-1:0]  enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DIM_W'(1);
			height_q <= CFG_DIM_W'(1);
			enable_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[CFG_DIM_W-1:0];
				REG_MAPS_ENABLE:  enable_q <= cfg_data[CFG_EN_W-1:0];
				default: ;
			endcase
		end
	end

	// raster position and running totals
	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;
	logic [COUNT_W-1:0] count_q;
	logic [CHAN_W-1:0]  red_q;
	logic [CHAN_W-1:0]  green_q;
	logic [CHAN_W-1:0]  blue_q;

	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic               row_end;
	logic               frame_end;

	logic               differs;
	logic [CHAN_W-1:0]  dr;
	logic [CHAN_W-1:0]  dg;
	logic [CHAN_W-1:0]  db;
	logic [COUNT_W-1:0] count_nxt;
	logic [CHAN_W-1:0]  red_nxt;
	logic [CHAN_W-1:0]  green_nxt;
	logic [CHAN_W-1:0]  blue_nxt;
	logic [CHAN_W-1:0]  mask_px;
	logic [PIXEL_W-1:0] rgb_px;
	logic [PIXEL_W-1:0] white_px;

	assign w_eff     = clamp_dim(width_q);
	assign h_eff     = clamp_dim(height_q);
	assign row_end   = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
	assign frame_end = row_end && ((DIM_W'(row_q) + DIM_W'(1)) >= h_eff);
	assign status.frame_end = frame_end;

	always_comb begin
		differs = baseline_pixel != test_pixel;
		dr = abs_chan(baseline_pixel[RED_LSB +: CHAN_W], test_pixel[RED_LSB +: CHAN_W]);
		dg = abs_chan(baseline_pixel[GREEN_LSB +: CHAN_W], test_pixel[GREEN_LSB +: CHAN_W]);
		db = abs_chan(baseline_pixel[BLUE_LSB +: CHAN_W], test_pixel[BLUE_LSB +: CHAN_W]);
		count_nxt = (differs && count_q != COUNT_MAX) ? count_q + COUNT_W'(1) : count_q;
		red_nxt   = (differs && dr > red_q) ? dr : red_q;
		green_nxt = (differs && dg > green_q) ? dg : green_q;
		blue_nxt  = (differs && db > blue_q) ? db : blue_q;
		mask_px   = enable_q[EN_MASK] ? (differs ? '0 : CHAN_MAX) : '0;
		rgb_px    = (enable_q[EN_RGB] && differs) ? {ALPHA_OPAQUE, dr, dg, db} : '0;
		white_px  = enable_q[EN_WHITE] ? (differs ? WHITE_PIXEL : BLACK_PIXEL) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (cmd.take) begin
			if (frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				count_q <= '0;
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
			end else begin
				count_q <= count_nxt;
				red_q   <= red_nxt;
				green_q <= green_nxt;
				blue_q  <= blue_nxt;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	// last pixel of the frame waits here while the fraction is divided out
	logic               pend_differs_q;
	logic [CHAN_W-1:0]  pend_mask_q;
	logic [PIXEL_W-1:0] pend_rgb_q;
	logic [PIXEL_W-1:0] pend_white_q;
	logic [COUNT_W-1:0] pend_count_q;
	logic [CHAN_W-1:0]  pend_red_q;
	logic [CHAN_W-1:0]  pend_green_q;
	logic [CHAN_W-1:0]  pend_blue_q;

	always_ff @(posedge clk) begin
		if (cmd.take && frame_end) begin
			pend_differs_q <= differs;
			pend_mask_q    <= mask_px;
			pend_rgb_q     <= rgb_px;
			pend_white_q   <= white_px;
			pend_count_q   <= count_nxt;
			pend_red_q     <= red_nxt;
			pend_green_q   <= green_nxt;
			pend_blue_q    <= blue_nxt;
		end
	end

	// restoring divider, one quotient bit a cycle
	logic [TOT_W-1:0]  total_q;
	logic [REM_W-1:0]  rem_q;
	logic [FRAC_W-1:0] quot_q;
	logic [SUB_W-1:0]  tot_ext;
	logic [SUB_W-1:0]  cnt_ext;
	logic [SUB_W-1:0]  same;
	logic              rem_ge;
	logic [REM_W-1:0]  rem_sub;

	always_comb begin
		tot_ext = SUB_W'(total_q);
		cnt_ext = SUB_W'(pend_count_q);
		same    = (tot_ext > cnt_ext) ? tot_ext - cnt_ext : '0;
		rem_ge  = rem_q >= REM_W'(total_q);
		rem_sub = rem_ge ? rem_q - REM_W'(total_q) : rem_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul)
			total_q <= TOT_W'(w_eff) * TOT_W'(h_eff);
		if (cmd.rem_load) begin
			rem_q  <= REM_W'(same);
			quot_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= {rem_sub[REM_W-2:0], 1'b0};
			quot_q <= {quot_q[FRAC_W-2:0], rem_ge};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.take && !frame_end) begin
			pixel_differs      <= differs;
			mask_alpha         <= mask_px;
			rgb_diff_pixel     <= rgb_px;
			white_diff_pixel   <= white_px;
			frame_done         <= 1'b0;
			differing_count    <= count_nxt;
			max_red_diff       <= red_nxt;
			max_green_diff     <= green_nxt;
			max_blue_diff      <= blue_nxt;
			identical_fraction <= '0;
		end else if (cmd.pend_emit) begin
			pixel_differs      <= pend_differs_q;
			mask_alpha         <= pend_mask_q;
			rgb_diff_pixel     <= pend_rgb_q;
			white_diff_pixel   <= pend_white_q;
			frame_done         <= 1'b1;
			differing_count    <= pend_count_q;
			max_red_diff       <= pend_red_q;
			max_green_diff     <= pend_green_q;
			max_blue_diff      <= pend_blue_q;
			identical_fraction <= quot_q;
		end
	end

endmodule

`default_nettype wire
